>>> rtl/slve_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slve_pkg
// Shared types, constants and segment tables for the segment LCD encoder.
// ----------------------------------------------------------------------------
package slve_pkg;

    // Command codes as they arrive on the input channel.
    typedef enum logic [2:0] {
        CMD_VOLTAGE = 3'd0,
        CMD_TEMP    = 3'd1,
        CMD_PERCENT = 3'd2,
        CMD_BAR     = 3'd3,
        CMD_ICON    = 3'd4
    } cmd_t;

    localparam int SHADOW_DEPTH = 11;

    // Segment RAM nibble addresses of each shadow byte.
    localparam logic [4:0] ADDR_VOLT_HUND = 5'd0;
    localparam logic [4:0] ADDR_VOLT_TENS = 5'd2;
    localparam logic [4:0] ADDR_VOLT_UNIT = 5'd4;
    localparam logic [4:0] ADDR_TEMP_UNIT = 5'd26;
    localparam logic [4:0] ADDR_TEMP_TENS = 5'd28;
    localparam logic [4:0] ADDR_PCT_LOW   = 5'd15;
    localparam logic [4:0] ADDR_PCT_HIGH  = 5'd17;
    localparam logic [4:0] ADDR_BAR_A     = 5'd30;
    localparam logic [4:0] ADDR_BAR_B     = 5'd19;
    localparam logic [4:0] ADDR_BAR_C     = 5'd13;
    localparam logic [4:0] ADDR_ICON      = 5'd14;

    // Extra segment bits.
    localparam logic [7:0] SEG_POINT   = 8'h10;
    localparam logic [7:0] SEG_MARK    = 8'h08;
    localparam logic [7:0] SEG_MINUS   = 8'h20;
    localparam logic [7:0] SEG_FRAME   = 8'h01;
    localparam logic [3:0] BAR_FULL    = 4'd11;

    // Classified command, as it travels from the front to the back.
    typedef struct packed {
        cmd_t       cmd;
        logic       en;
        logic       neg;
        logic [3:0] units;      // pos mod 10
        logic [6:0] tens_q;     // pos div 10
        logic       mag_big;    // negative magnitude above nine
        logic [3:0] mag_digit;
        logic [3:0] bar_lvl;    // BAR_FULL above ten
        logic [3:0] mask;
    } item_t;

    // One pending byte write.
    typedef struct packed {
        logic [4:0] addr;
        logic [7:0] data;
    } wr_t;

    // Bar bits for the three bar bytes.
    typedef struct packed {
        logic [2:0] b7;
        logic [3:0] b8;
        logic [7:0] b9;
    } bar_t;

    // Digit patterns for the left half of the glass; other codes are blank.
    function automatic logic [7:0] digit_left(input logic [3:0] d);
        logic [7:0] seg;
        case (d)
            4'd0:    seg = 8'hAF;
            4'd1:    seg = 8'hA0;
            4'd2:    seg = 8'hCB;
            4'd3:    seg = 8'hE9;
            4'd4:    seg = 8'hE4;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h6F;
            4'd7:    seg = 8'hA8;
            4'd8:    seg = 8'hEF;
            4'd9:    seg = 8'hED;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    // Digit patterns for the right half of the glass; other codes are blank.
    function automatic logic [7:0] digit_right(input logic [3:0] d);
        logic [7:0] seg;
        case (d)
            4'd0:    seg = 8'hF5;
            4'd1:    seg = 8'h05;
            4'd2:    seg = 8'hB6;
            4'd3:    seg = 8'h97;
            4'd4:    seg = 8'h47;
            4'd5:    seg = 8'hD3;
            4'd6:    seg = 8'hF3;
            4'd7:    seg = 8'h85;
            4'd8:    seg = 8'hF7;
            4'd9:    seg = 8'hD7;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    // Bar segment bits by level; BAR_FULL lights all of b7 and b8 and 8'h0E in b9.
    function automatic bar_t bar_bits(input logic [3:0] lvl);
        bar_t b;
        case (lvl)
            4'd0:    b = '{b7: 3'h0, b8: 4'h0, b9: 8'h00};
            4'd1:    b = '{b7: 3'h4, b8: 4'h0, b9: 8'h00};
            4'd2:    b = '{b7: 3'h6, b8: 4'h0, b9: 8'h00};
            4'd3:    b = '{b7: 3'h7, b8: 4'h0, b9: 8'h00};
            4'd4:    b = '{b7: 3'h7, b8: 4'h1, b9: 8'h00};
            4'd5:    b = '{b7: 3'h7, b8: 4'h3, b9: 8'h00};
            4'd6:    b = '{b7: 3'h7, b8: 4'h7, b9: 8'h00};
            4'd7:    b = '{b7: 3'h7, b8: 4'hF, b9: 8'h00};
            4'd8:    b = '{b7: 3'h7, b8: 4'hF, b9: 8'h78};
            4'd9:    b = '{b7: 3'h7, b8: 4'hF, b9: 8'h3C};
            4'd10:   b = '{b7: 3'h7, b8: 4'hF, b9: 8'h1E};
            default: b = '{b7: 3'h7, b8: 4'hF, b9: 8'h0E};
        endcase
        return b;
    endfunction

endpackage : slve_pkg
`default_nettype wire

>>> rtl/segment_lcd_value_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_lcd_value_encoder_top
// Display commands in, segment RAM byte writes out, with an 11-byte shadow.
// ----------------------------------------------------------------------------
//  Channel   Direction   Handshake             Payload
//  in        input       in_valid / in_stall   command, value, enable_flag
//  out       output      out_valid / out_stall lcd_address, lcd_byte, last_write
//
//  A command enters whenever the two-entry queue has room.
//  The back end takes one beat per write: three writes per voltage or bar
//  command, two for temperature or percent, one for an icon change.
//  Unused codes and empty icon masks are taken and give no beats.
//  Reset clears the shadow to zero and empties the queue and write list.
//  A stall on out holds the current beat; in stalls once two commands wait.
// ----------------------------------------------------------------------------
module segment_lcd_value_encoder_top
    import slve_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic [2:0]         command,
    input  wire logic signed [10:0] value,
    input  wire logic               enable_flag,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      logic [4:0]         lcd_address,
    output      logic [7:0]         lcd_byte,
    output      logic               last_write
);

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_valid;
    item_t front_item;
    item_t q_item;

    // Front end: accept and classify.
    slve_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .value       (value),
        .enable_flag (enable_flag),
        .q_full      (q_full),
        .push        (push),
        .item        (front_item)
    );

    // Queue between the two halves.
    slve_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // Back end: shadow update and write sequencing.
    slve_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .lcd_address (lcd_address),
        .lcd_byte    (lcd_byte),
        .last_write  (last_write)
    );

endmodule : segment_lcd_value_encoder_top
`default_nettype wire

>>> rtl/slve_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slve_front
// Accepts command beats, clamps and splits the operand, drops no-op commands.
// ----------------------------------------------------------------------------
module slve_front
    import slve_pkg::*;
(
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic [2:0]         command,
    input  wire logic signed [10:0] value,
    input  wire logic               enable_flag,
    input  wire logic               q_full,
    output      logic               push,
    output      item_t              item
);

    logic [10:0] raw;
    logic        neg;
    logic [9:0]  pos;
    logic [10:0] mag;
    logic [17:0] prod;
    logic [6:0]  q1;
    logic [9:0]  q1x10;
    logic [9:0]  rem;
    logic        keep;

    // Clamp at zero and form the magnitude of a negative value.
    assign raw = value;
    assign neg = raw[10];
    assign pos = neg ? 10'd0 : raw[9:0];
    assign mag = ~raw + 11'd1;

    // Divide by ten through the reciprocal 205/2048, exact below 1029.
    assign prod  = 18'(pos) * 18'd205;
    assign q1    = prod[17:11];
    assign q1x10 = {q1, 3'b000} + {2'b00, q1, 1'b0};
    assign rem   = pos - q1x10;

    // Classified beat.
    always_comb
    begin
        item.cmd       = cmd_t'(command);
        item.en        = enable_flag;
        item.neg       = neg;
        item.units     = rem[3:0];
        item.tens_q    = q1;
        item.mag_big   = (mag > 11'd9);
        item.mag_digit = mag[3:0];
        item.bar_lvl   = (pos > 10'd10) ? BAR_FULL : pos[3:0];
        item.mask      = raw[3:0];
    end

    // Unused codes and an empty icon mask change nothing and are dropped.
    always_comb
    begin
        case (command)
            CMD_VOLTAGE, CMD_TEMP, CMD_PERCENT, CMD_BAR: keep = 1'b1;
            CMD_ICON: keep = (raw[3:0] != 4'd0);
            default:  keep = 1'b0;
        endcase
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full && keep;

endmodule : slve_front
`default_nettype wire

>>> rtl/slve_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slve_queue
// Two-entry queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module slve_queue
    import slve_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output      logic  full,
    output      logic  q_valid,
    output      item_t q_item
);

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule : slve_queue
`default_nettype wire

>>> rtl/slve_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slve_back
// Updates the segment shadow for one command and plays out its byte writes.
// ----------------------------------------------------------------------------
module slve_back
    import slve_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire item_t      q_item,
    output      logic       pop,
    output      logic       out_valid,
    input  wire logic       out_stall,
    output      logic [4:0] lcd_address,
    output      logic [7:0] lcd_byte,
    output      logic       last_write
);

    logic [7:0] shadow_reg  [SHADOW_DEPTH];
    logic [7:0] shadow_next [SHADOW_DEPTH];
    wr_t        slot_reg    [3];
    wr_t        slot_next   [3];
    wr_t        load        [3];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] load_cnt;
    logic       out_fire;

    logic [14:0] prod;
    logic [3:0]  q2;
    logic [6:0]  q2x10;
    logic [6:0]  rem;
    logic [3:0]  tens;
    logic [3:0]  hund;
    logic        big;
    bar_t        bar;

    // Second decimal split: tens and hundreds from pos div 10.
    assign prod  = 15'(q_item.tens_q) * 15'd205;
    assign q2    = prod[14:11];
    assign q2x10 = {q2, 3'b000} + {2'b00, q2, 1'b0};
    assign rem   = q_item.tens_q - q2x10;
    assign tens  = rem[3:0];
    assign hund  = (q2 >= 4'd10) ? (q2 - 4'd10) : q2;
    assign big   = (q_item.tens_q >= 7'd10);
    assign bar   = bar_bits(q_item.bar_lvl);

    // Handshake: take a new command once the last pending write leaves.
    assign out_valid   = (cnt_reg != 2'd0);
    assign out_fire    = out_valid && !out_stall;
    assign pop         = q_valid && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !out_stall));
    assign lcd_address = slot_reg[0].addr;
    assign lcd_byte    = slot_reg[0].data;
    assign last_write  = (cnt_reg == 2'd1);

    // Shadow update and write list of the command at the head of the queue.
    always_comb
    begin
        for (int i = 0; i < SHADOW_DEPTH; i++)
        begin
            shadow_next[i] = shadow_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            load[i] = '0;
        end
        load_cnt = 2'd0;
        case (q_item.cmd)
            CMD_VOLTAGE:
            begin
                shadow_next[0] = digit_left(hund) | SEG_POINT;
                shadow_next[1] = digit_left(tens) | SEG_POINT;
                shadow_next[2] = digit_left(q_item.units) | SEG_POINT;
                load[0]  = '{addr: ADDR_VOLT_HUND, data: shadow_next[0]};
                load[1]  = '{addr: ADDR_VOLT_TENS, data: shadow_next[1]};
                load[2]  = '{addr: ADDR_VOLT_UNIT, data: shadow_next[2]};
                load_cnt = 2'd3;
            end
            CMD_TEMP:
            begin
                if (!q_item.neg)
                begin
                    shadow_next[3] = digit_right(q_item.units) | SEG_MARK;
                    shadow_next[4] = digit_right(tens) | (big ? SEG_MARK : 8'h00);
                end
                else
                begin
                    shadow_next[3] = shadow_reg[3] | SEG_MINUS;
                    shadow_next[4] = (q_item.mag_big ? 8'h00 : digit_right(q_item.mag_digit))
                                     | SEG_MARK;
                end
                shadow_next[7] = shadow_reg[7] | SEG_MARK;
                load[0]  = '{addr: ADDR_TEMP_UNIT, data: shadow_next[3]};
                load[1]  = '{addr: ADDR_TEMP_TENS, data: shadow_next[4]};
                load_cnt = 2'd2;
            end
            CMD_PERCENT:
            begin
                if (q_item.en)
                begin
                    shadow_next[5] = digit_right(q_item.units) | SEG_MARK;
                    shadow_next[6] = digit_right(tens) | (big ? SEG_MARK : 8'h00);
                end
                else
                begin
                    shadow_next[5] = 8'h00;
                    shadow_next[6] = digit_right(q_item.units);
                end
                load[0]  = '{addr: ADDR_PCT_LOW, data: shadow_next[5]};
                load[1]  = '{addr: ADDR_PCT_HIGH, data: shadow_next[6]};
                load_cnt = 2'd2;
            end
            CMD_BAR:
            begin
                shadow_next[7] = {shadow_reg[7][7:3], bar.b7};
                shadow_next[8] = {shadow_reg[8][7:4], bar.b8};
                shadow_next[9] = {shadow_reg[9][7], bar.b9[6:1], q_item.en};
                load[0]  = '{addr: ADDR_BAR_A, data: shadow_next[7]};
                load[1]  = '{addr: ADDR_BAR_B, data: shadow_next[8]};
                load[2]  = '{addr: ADDR_BAR_C, data: shadow_next[9]};
                load_cnt = 2'd3;
            end
            CMD_ICON:
            begin
                if (q_item.en)
                begin
                    shadow_next[10] = shadow_reg[10] | {4'h0, q_item.mask};
                end
                else
                begin
                    shadow_next[10] = shadow_reg[10] & ~{4'h0, q_item.mask};
                end
                load[0]  = '{addr: ADDR_ICON, data: shadow_next[10]};
                load_cnt = 2'd1;
            end
            default:
            begin
                load_cnt = 2'd0;
            end
        endcase
    end

    // Write list: shift out on each accepted beat, reload on a new command.
    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        slot_next[2] = slot_reg[2];
        cnt_next     = cnt_reg;
        if (out_fire)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
        if (pop)
        begin
            slot_next[0] = load[0];
            slot_next[1] = load[1];
            slot_next[2] = load[2];
            cnt_next     = load_cnt;
        end
    end

    // Shadow and write counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SHADOW_DEPTH; i++)
            begin
                shadow_reg[i] <= 8'h00;
            end
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (pop)
            begin
                for (int i = 0; i < SHADOW_DEPTH; i++)
                begin
                    shadow_reg[i] <= shadow_next[i];
                end
            end
            cnt_reg <= cnt_next;
        end
    end

    // Pending write payloads.
    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
        slot_reg[2] <= slot_next[2];
    end

`ifndef SYNTHESIS
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && (cnt_reg == 2'd1) && !q_valid) |=> !out_valid)
        else $error("write list did not drain after last beat");
    a_mark_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        shadow_reg[7][3] |=> shadow_reg[7][3])
        else $error("temperature mark bit cleared");
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (cnt_reg != 2'd0)) |-> (out_fire && last_write))
        else $error("command taken over pending writes");
`endif

endmodule : slve_back
`default_nettype wire

>>> bench/tb_segment_lcd_value_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_lcd_value_encoder_top
// Drives display commands into the segment LCD encoder and checks every
// segment byte write. The bench keeps its own segment shadow and works out the
// writes of each accepted command. Each output beat is compared in order.
// Both channels idle and stall at random. One phase holds the output for a
// long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module tb_segment_lcd_value_encoder_top;
    import slve_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 80;
    localparam int SETTLE_WAIT  = 20;
    localparam int RANDOM_ITEMS = 90;

    // One expected segment byte write.
    typedef struct packed {
        logic [4:0] addr;
        logic [7:0] data;
        logic       last;
    } lcd_write_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [2:0]         command     = CMD_VOLTAGE;
    logic signed [10:0] value       = '0;
    logic               enable_flag = 1'b0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [4:0]         lcd_address;
    logic [7:0]         lcd_byte;
    logic               last_write;

    // Seven-segment glyphs for the two halves of the glass; the last is blank.
    logic [7:0] left_glyph  [0:10] = '{8'hAF, 8'hA0, 8'hCB, 8'hE9, 8'hE4, 8'h6D,
                                       8'h6F, 8'hA8, 8'hEF, 8'hED, 8'h00};
    logic [7:0] right_glyph [0:10] = '{8'hF5, 8'h05, 8'hB6, 8'h97, 8'h47, 8'hD3,
                                       8'hF3, 8'h85, 8'hF7, 8'hD7, 8'h00};

    logic [7:0] lcd_shadow [SHADOW_DEPTH];
    lcd_write_t lcd_writes [$];
    lcd_write_t expected_write;
    int         fail_count  = 0;
    int         cycle_count = 0;
    bit         tx_quiet    = 1'b0;
    bit         rx_quiet    = 1'b0;
    bit         hold_off_pending = 1'b0;

    segment_lcd_value_encoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .value       (value),
        .enable_flag (enable_flag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .lcd_address (lcd_address),
        .lcd_byte    (lcd_byte),
        .last_write  (last_write)
    );

    always #1 clk = ~clk;

    initial begin
        for (int i = 0; i < SHADOW_DEPTH; i++)
        begin
            lcd_shadow[i] = 8'h00;
        end
    end

    // Queue the write of one shadow byte at its segment RAM address.
    task automatic queue_write(input logic [4:0] addr, input int idx, input logic last);
        lcd_write_t w;
        w.addr = addr;
        w.data = lcd_shadow[idx];
        w.last = last;
        lcd_writes.push_back(w);
    endtask

    // Update the shadow for one command and queue the writes it sends.
    task automatic predict_writes(input logic [2:0] code, input logic [10:0] raw,
                                  input logic en);
        logic        neg;
        int unsigned pos;
        int unsigned mag;
        logic [7:0]  b7;
        logic [7:0]  b8;
        logic [7:0]  b9;
        logic [3:0]  mask;
        neg  = raw[10];
        pos  = neg ? 0 : int'(raw);
        mag  = neg ? (2048 - int'(raw)) : int'(raw);
        mask = raw[3:0];
        b7   = 8'h00;
        b8   = 8'h00;
        b9   = 8'h00;
        case (code)
            CMD_VOLTAGE:
            begin
                lcd_shadow[2] = left_glyph[pos % 10] | SEG_POINT;
                lcd_shadow[1] = left_glyph[(pos / 10) % 10] | SEG_POINT;
                lcd_shadow[0] = left_glyph[(pos / 100) % 10] | SEG_POINT;
                queue_write(ADDR_VOLT_HUND, 0, 1'b0);
                queue_write(ADDR_VOLT_TENS, 1, 1'b0);
                queue_write(ADDR_VOLT_UNIT, 2, 1'b1);
            end
            CMD_TEMP:
            begin
                if (!neg)
                begin
                    lcd_shadow[3] = right_glyph[pos % 10] | SEG_MARK;
                    lcd_shadow[4] = right_glyph[(pos / 10) % 10];
                    if (pos >= 100)
                    begin
                        lcd_shadow[4] = lcd_shadow[4] | SEG_MARK;
                    end
                end
                else
                begin
                    // Minus mark keeps the units digit; big magnitudes go blank.
                    lcd_shadow[3] = lcd_shadow[3] | SEG_MINUS;
                    lcd_shadow[4] = right_glyph[(mag > 9) ? 10 : mag] | SEG_MARK;
                end
                lcd_shadow[7] = lcd_shadow[7] | SEG_MARK;
                queue_write(ADDR_TEMP_UNIT, 3, 1'b0);
                queue_write(ADDR_TEMP_TENS, 4, 1'b1);
            end
            CMD_PERCENT:
            begin
                if (en)
                begin
                    lcd_shadow[5] = right_glyph[pos % 10] | SEG_MARK;
                    lcd_shadow[6] = right_glyph[(pos / 10) % 10];
                    if (pos >= 100)
                    begin
                        lcd_shadow[6] = lcd_shadow[6] | SEG_MARK;
                    end
                end
                else
                begin
                    lcd_shadow[5] = 8'h00;
                    lcd_shadow[6] = right_glyph[pos % 10];
                end
                queue_write(ADDR_PCT_LOW, 5, 1'b0);
                queue_write(ADDR_PCT_HIGH, 6, 1'b1);
            end
            CMD_BAR:
            begin
                // Bar segments fill from byte 7 through byte 8 into byte 9.
                if (pos > 10)
                begin
                    b7 = 8'h07;
                    b8 = 8'h0F;
                    b9 = 8'h0F;
                end
                else if (pos == 0)
                begin
                    b7 = 8'h00;
                end
                else if (pos < 4)
                begin
                    b7 = (8'hF0 >> (pos + 1)) & 8'h07;
                end
                else if (pos < 8)
                begin
                    b7 = 8'h07;
                    b8 = (8'h1E >> (8 - pos)) & 8'h0F;
                end
                else
                begin
                    b7 = 8'h07;
                    b8 = 8'h0F;
                    b9 = (8'h78 >> (pos - 8)) & 8'h7E;
                end
                lcd_shadow[7] = (lcd_shadow[7] & 8'hF8) | (b7 & 8'h07);
                lcd_shadow[8] = (lcd_shadow[8] & 8'hF0) | (b8 & 8'h0F);
                lcd_shadow[9] = (lcd_shadow[9] & 8'h81) | (b9 & 8'h7E);
                lcd_shadow[9][0] = en;
                queue_write(ADDR_BAR_A, 7, 1'b0);
                queue_write(ADDR_BAR_B, 8, 1'b0);
                queue_write(ADDR_BAR_C, 9, 1'b1);
            end
            CMD_ICON:
            begin
                if (mask != 4'h0)
                begin
                    if (en)
                    begin
                        lcd_shadow[10] = lcd_shadow[10] | {4'h0, mask};
                    end
                    else
                    begin
                        lcd_shadow[10] = lcd_shadow[10] & ~{4'h0, mask};
                    end
                    queue_write(ADDR_ICON, 10, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Input side: every accepted beat updates the prediction.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_writes(command, value, enable_flag);
        end
    end

    // Output side: every accepted beat is checked against the oldest write.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (lcd_writes.size() == 0)
            begin
                $error("unexpected write: lcd_address %0d lcd_byte %02h last_write %0b",
                       lcd_address, lcd_byte, last_write);
                fail_count++;
            end
            else
            begin
                expected_write = lcd_writes.pop_front();
                if (lcd_address !== expected_write.addr)
                begin
                    $error("lcd_address: expected %0d, actual %0d",
                           expected_write.addr, lcd_address);
                    fail_count++;
                end
                if (lcd_byte !== expected_write.data)
                begin
                    $error("lcd_byte: expected %02h, actual %02h",
                           expected_write.data, lcd_byte);
                    fail_count++;
                end
                if (last_write !== expected_write.last)
                begin
                    $error("last_write: expected %0b, actual %0b",
                           expected_write.last, last_write);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_segment_lcd_value_encoder_top: FAIL");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (rx_quiet || $urandom_range(0, 3) != 0)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    // Offer one command and hold it until the block takes the beat.
    task automatic send_command(input logic [2:0] code, input logic [10:0] operand,
                                input logic en);
        int gap;
        in_valid    <= 1'b1;
        command     <= code;
        value       <= operand;
        enable_flag <= en;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every predicted write has come out.
    // It waits on the clock first so that the last accepted beat is predicted.
    task automatic drain_writes();
        in_valid <= 1'b0;
        @(posedge clk);
        while (lcd_writes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Operand mix: mostly small values, some full range, some edges.
    function automatic logic [10:0] pick_operand();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            return 11'($urandom_range(0, 120));
        end
        if (r < 8)
        begin
            return 11'($urandom);
        end
        case ($urandom_range(0, 10))
            0:       return 11'd0;
            1:       return 11'd9;
            2:       return 11'd10;
            3:       return 11'd11;
            4:       return 11'd99;
            5:       return 11'd100;
            6:       return 11'd1023;
            7:       return -11'sd1;
            8:       return -11'sd9;
            9:       return -11'sd10;
            default: return -11'sd1024;
        endcase
    endfunction

    // Unused codes and empty icon masks leave the display untouched.
    function automatic bit is_ignored(input logic [2:0] code, input logic [10:0] operand);
        return (code > CMD_ICON) || (code == CMD_ICON && operand[3:0] == 4'h0);
    endfunction

    // Digits: voltage wrap past 999, temperature mark and minus, percent sign.
    task automatic test_digit_commands();
        send_command(CMD_VOLTAGE, 11'd987, 1'b0);
        send_command(CMD_VOLTAGE, 11'd1023, 1'b1);
        send_command(CMD_VOLTAGE, -11'sd1, 1'b0);
        send_command(CMD_TEMP, 11'd100, 1'b0);
        send_command(CMD_TEMP, 11'd7, 1'b1);
        send_command(CMD_TEMP, -11'sd9, 1'b0);
        send_command(CMD_TEMP, -11'sd10, 1'b0);
        send_command(CMD_TEMP, -11'sd1024, 1'b1);
        send_command(CMD_PERCENT, 11'd100, 1'b1);
        send_command(CMD_PERCENT, 11'd57, 1'b0);
        send_command(CMD_PERCENT, -11'sd3, 1'b1);
        drain_writes();
    endtask

    // Bar levels across every range, frame on and off, icons and unused codes.
    task automatic test_bar_icon_commands();
        send_command(CMD_BAR, 11'd2, 1'b1);
        send_command(CMD_BAR, 11'd5, 1'b0);
        send_command(CMD_BAR, 11'd9, 1'b1);
        send_command(CMD_BAR, 11'd11, 1'b0);
        send_command(CMD_BAR, -11'sd1, 1'b1);
        send_command(CMD_ICON, 11'h00F, 1'b1);
        send_command(CMD_ICON, 11'h005, 1'b0);
        send_command(CMD_ICON, 11'h7F0, 1'b1);
        send_command(3'd5, 11'h3FF, 1'b1);
        send_command(3'd6, 11'h400, 1'b0);
        send_command(3'd7, 11'h7FF, 1'b1);
        drain_writes();
    endtask

    // Hold the output for a long stretch while commands keep arriving.
    task automatic test_output_backpressure();
        tx_quiet = 1'b1;
        hold_off_pending = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            send_command((i % 2 == 0) ? CMD_VOLTAGE : CMD_BAR, pick_operand(),
                         1'($urandom));
        end
        tx_quiet = 1'b0;
        drain_writes();
    endtask

    // Random commands; the first stretch runs with no idling on either side.
    task automatic test_random_commands();
        int          counted;
        logic [2:0]  code;
        logic [10:0] operand;
        counted = 0;
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted == 30)
            begin
                tx_quiet = 1'b0;
                rx_quiet = 1'b0;
            end
            code    = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
            operand = pick_operand();
            send_command(code, operand, 1'($urandom));
            if (!is_ignored(code, operand))
            begin
                counted++;
            end
        end
        drain_writes();
    endtask

    // Test sequence.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_digit_commands();
        test_bar_icon_commands();
        test_output_backpressure();
        test_random_commands();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (fail_count == 0 && lcd_writes.size() == 0)
        begin
            $display("tb_segment_lcd_value_encoder_top: PASS");
        end
        else
        begin
            $display("tb_segment_lcd_value_encoder_top: FAIL");
        end
        $finish;
    end

endmodule : tb_segment_lcd_value_encoder_top
